// ===== rtl/c6502as_pkg.sv =====
// Package for the 6502 addressing sequencer: item structs, mode and bus codes.
// No dependencies.
package c6502as_pkg;

	localparam logic [1:0] BUS_NONE  = 2'd0;
	localparam logic [1:0] BUS_READ  = 2'd1;
	localparam logic [1:0] BUS_WRITE = 2'd2;

	localparam logic [3:0] M_IMM     = 4'd0;
	localparam logic [3:0] M_ABS     = 4'd1;
	localparam logic [3:0] M_ZP      = 4'd2;
	localparam logic [3:0] M_IMP     = 4'd3;
	localparam logic [3:0] M_ABSX    = 4'd4;
	localparam logic [3:0] M_ZPX     = 4'd5;
	localparam logic [3:0] M_INDX    = 4'd6;
	localparam logic [3:0] M_INDY    = 4'd7;
	localparam logic [3:0] M_REL     = 4'd8;
	localparam logic [3:0] M_ACC     = 4'd9;
	localparam logic [3:0] M_ZP_RMW  = 4'd10;
	localparam logic [3:0] M_ZPX_RMW = 4'd11;
	localparam logic [3:0] M_ABS_RMW = 4'd12;
	localparam logic [3:0] M_ABSX_RMW = 4'd13;

	localparam logic KIND_START = 1'b0;

	typedef struct packed {
		logic        kind;
		logic [3:0]  mode;
		logic        store_op;
		logic [7:0]  index_value;
		logic [7:0]  x_value;
		logic [7:0]  y_value;
		logic [15:0] start_pc;
		logic [7:0]  read_data;
		logic [7:0]  store_data;
		logic [7:0]  acc_value;
		logic        branch_taken;
		logic [7:0]  alu_result;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  bus_op;
		logic [15:0] bus_address;
		logic [7:0]  write_data;
		logic [7:0]  operand;
		logic [15:0] effective_address;
		logic        execute;
		logic        done_res;
		logic [15:0] pc_out;
		logic [7:0]  acc_out;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  step;
		logic [3:0]  cur_mode;
		logic [15:0] addr_latch;
		logic [7:0]  data_latch;
		logic [15:0] pc_reg;
		logic        store_f;
		logic        branch_f;
		logic [7:0]  idx;
		logic [7:0]  xv;
		logic [7:0]  yv;
	} seq_state_t;

endpackage

// ===== rtl/cpu6502_addressing_sequencer_core.sv =====
// Top level of the 6502 addressing-mode bus cycle sequencer.
// Uses c6502as_pkg and c6502as_step.
//
// One input item is one CPU bus cycle: it is registered in stage 1, run through the
// cycle logic and its result item lands in the output register. A new item is
// taken every clock while the output register is free or being drained;
// throughput is one item per cycle.
module cpu6502_addressing_sequencer_core import c6502as_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	in_item_t   item_s1;
	logic       valid_s1;
	seq_state_t state_q;
	seq_state_t state_d;
	out_item_t  res_d;
	logic       adv_s1;

	// stage 1 moves when the output register can take its result
	assign adv_s1 = !(out_valid && out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	c6502as_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_d),
		.res  (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
			state_q <= '0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (adv_s1) out_valid <= valid_s1;
			if (valid_s1 && adv_s1) state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_s1 <= in_data;
		if (valid_s1 && adv_s1) out_data <= res_d;
	end

endmodule

// ===== rtl/c6502as_step.sv =====
// Combinational next-state and bus cycle logic for one item.
// Uses c6502as_pkg.
module c6502as_step import c6502as_pkg::*; (
	input  in_item_t   item,
	input  seq_state_t cur,
	output seq_state_t nxt,
	output out_item_t  res
);

	always_comb begin
		logic [2:0]  s;
		logic [2:0]  nstep;
		logic        done;
		logic [15:0] sum;
		logic [15:0] base;
		logic [7:0]  ix;
		logic [15:0] t;
		nxt = cur;
		res = '0;
		s = cur.step;
		nstep = s + 3'd1;
		done = 1'b0;
		sum = '0;
		base = '0;
		ix = '0;
		t = '0;
		if (item.kind == KIND_START) begin
			nxt.cur_mode = item.mode;
			nxt.store_f = item.store_op;
			nxt.branch_f = item.branch_taken;
			nxt.idx = item.index_value;
			nxt.xv = item.x_value;
			nxt.yv = item.y_value;
			nxt.pc_reg = item.start_pc;
			nxt.addr_latch = '0;
			nxt.data_latch = '0;
			nxt.step = 3'd1;
		end else if (s != 3'd0) begin
			case (cur.cur_mode) inside
				M_IMM: begin
					if (s == 3'd1) begin
						res.bus_op = BUS_READ; res.bus_address = cur.pc_reg;
						nxt.pc_reg = cur.pc_reg + 16'd1;
					end else begin
						nxt.data_latch = item.read_data; res.execute = 1'b1; done = 1'b1;
					end
				end
				M_ABS, M_ZP, M_ABSX, M_ZPX, M_INDX, M_INDY: begin
					// shared shape: fetch, address build, optional index, access, finish
					if (s == 3'd1) begin
						res.bus_op = BUS_READ; res.bus_address = cur.pc_reg;
						nxt.pc_reg = cur.pc_reg + 16'd1;
					end else begin
						case (cur.cur_mode)
							M_ABS: begin
								if (s == 3'd2) begin
									nxt.data_latch = item.read_data;
									res.bus_op = BUS_READ; res.bus_address = cur.pc_reg;
									nxt.pc_reg = cur.pc_reg + 16'd1;
								end else if (s == 3'd3) begin
									nxt.addr_latch = {item.read_data, cur.data_latch};
								end
							end
							M_ZP: begin
								if (s == 3'd2) nxt.addr_latch = {8'd0, item.read_data};
							end
							M_ABSX: begin
								if (s == 3'd2) begin
									nxt.data_latch = item.read_data;
									res.bus_op = BUS_READ; res.bus_address = cur.pc_reg;
									nxt.pc_reg = cur.pc_reg + 16'd1;
								end else if (s == 3'd3) begin
									base = {item.read_data, cur.data_latch};
									ix = cur.idx;
								end
							end
							M_ZPX: begin
								if (s == 3'd2) begin
									res.bus_op = BUS_READ;
									res.bus_address = {8'd0, item.read_data};
									nxt.addr_latch = {8'd0, item.read_data + cur.idx};
								end
							end
							M_INDX: begin
								if (s == 3'd2) begin
									res.bus_op = BUS_READ;
									res.bus_address = {8'd0, item.read_data};
									nxt.data_latch = item.read_data + cur.xv;
								end else if (s == 3'd3) begin
									res.bus_op = BUS_READ;
									res.bus_address = {8'd0, cur.data_latch};
									nxt.data_latch = cur.data_latch + 8'd1;
								end else if (s == 3'd4) begin
									nxt.addr_latch = {8'd0, item.read_data};
									res.bus_op = BUS_READ;
									res.bus_address = {8'd0, cur.data_latch};
								end else if (s == 3'd5) begin
									nxt.addr_latch = {item.read_data, cur.addr_latch[7:0]};
								end
							end
							default: begin // indirect Y
								if (s == 3'd2) begin
									nxt.data_latch = item.read_data + 8'd1;
									res.bus_op = BUS_READ;
									res.bus_address = {8'd0, item.read_data};
								end else if (s == 3'd3) begin
									nxt.addr_latch = {8'd0, item.read_data};
									res.bus_op = BUS_READ;
									res.bus_address = {8'd0, cur.data_latch};
								end else if (s == 3'd4) begin
									base = {item.read_data, cur.addr_latch[7:0]};
									ix = cur.yv;
								end
							end
						endcase
						// index add step (absolute indexed s3, indirect Y s4)
						if ((cur.cur_mode == M_ABSX && s == 3'd3) ||
							(cur.cur_mode == M_INDY && s == 3'd4)) begin
							sum = base + {8'd0, ix};
							nxt.addr_latch = sum;
							res.bus_op = BUS_READ;
							if (cur.store_f || sum[15:8] != base[15:8]) begin
								res.bus_address = {base[15:8], sum[7:0]};
							end else begin
								res.bus_address = sum;
								nstep = s + 3'd2;
							end
						end
						// access cycle and finish cycle
						if ((cur.cur_mode == M_ABS && s == 3'd3) ||
							(cur.cur_mode == M_ZP && s == 3'd2) ||
							(cur.cur_mode == M_ABSX && s == 3'd4) ||
							(cur.cur_mode == M_ZPX && s == 3'd3) ||
							(cur.cur_mode == M_INDX && s == 3'd5) ||
							(cur.cur_mode == M_INDY && s == 3'd5)) begin
							res.bus_address = nxt.addr_latch;
							if (cur.store_f) begin
								res.bus_op = BUS_WRITE; res.write_data = item.store_data;
							end else begin
								res.bus_op = BUS_READ;
							end
						end else if ((cur.cur_mode == M_ABS && s >= 3'd4) ||
							(cur.cur_mode == M_ZP && s >= 3'd3) ||
							(cur.cur_mode == M_ABSX && s >= 3'd5) ||
							(cur.cur_mode == M_ZPX && s >= 3'd4) ||
							(cur.cur_mode == M_INDX && s >= 3'd6) ||
							(cur.cur_mode == M_INDY && s >= 3'd6)) begin
							if (!cur.store_f) nxt.data_latch = item.read_data;
							res.execute = 1'b1; done = 1'b1;
						end
					end
				end
				M_REL: begin
					if (s == 3'd1) begin
						res.bus_op = BUS_READ; res.bus_address = cur.pc_reg;
						nxt.pc_reg = cur.pc_reg + 16'd1;
					end else if (s == 3'd2) begin
						nxt.data_latch = item.read_data;
						t = {{8{item.read_data[7]}}, item.read_data};
						nxt.addr_latch = cur.pc_reg + t;
						if (cur.branch_f) begin
							res.bus_op = BUS_READ;
							res.bus_address = {cur.pc_reg[15:8], nxt.addr_latch[7:0]};
						end else begin
							done = 1'b1;
						end
					end else if (s == 3'd3 && cur.pc_reg[15:8] != cur.addr_latch[15:8]) begin
						res.bus_op = BUS_READ; res.bus_address = cur.addr_latch;
					end else begin
						nxt.pc_reg = cur.addr_latch; done = 1'b1;
					end
				end
				M_ACC: begin
					if (s == 3'd1) begin
						res.bus_op = BUS_READ; res.bus_address = cur.pc_reg;
						nxt.data_latch = item.acc_value;
					end else begin
						res.acc_out = item.alu_result; res.execute = 1'b1; done = 1'b1;
					end
				end
				M_ZP_RMW, M_ZPX_RMW, M_ABS_RMW, M_ABSX_RMW: begin
					if (s == 3'd1) begin
						res.bus_op = BUS_READ; res.bus_address = cur.pc_reg;
						nxt.pc_reg = cur.pc_reg + 16'd1;
					end else if (s == 3'd2) begin
						case (cur.cur_mode)
							M_ZP_RMW: begin
								nxt.addr_latch = {8'd0, item.read_data};
								res.bus_op = BUS_READ;
								res.bus_address = {8'd0, item.read_data};
							end
							M_ZPX_RMW: begin
								res.bus_op = BUS_READ;
								res.bus_address = {8'd0, item.read_data};
								nxt.addr_latch = {8'd0, item.read_data + cur.idx};
							end
							M_ABS_RMW: begin
								nxt.addr_latch = {8'd0, item.read_data};
								res.bus_op = BUS_READ; res.bus_address = cur.pc_reg;
								nxt.pc_reg = cur.pc_reg + 16'd1;
							end
							default: begin
								nxt.data_latch = item.read_data;
								res.bus_op = BUS_READ; res.bus_address = cur.pc_reg;
								nxt.pc_reg = cur.pc_reg + 16'd1;
							end
						endcase
					end else begin
						// offset so that the read is step 3 for every form but zero page
						logic [2:0] r;
						r = (cur.cur_mode == M_ZP_RMW) ? s + 3'd1 :
							(cur.cur_mode == M_ABSX_RMW) ? s - 3'd1 : s;
						if (cur.cur_mode == M_ABSX_RMW && s == 3'd3) begin
							res.bus_op = BUS_READ;
							res.bus_address = {item.read_data, cur.data_latch + cur.idx};
							nxt.addr_latch = {item.read_data, cur.data_latch} + {8'd0, cur.idx};
						end else if (r == 3'd3) begin
							if (cur.cur_mode == M_ABS_RMW)
								nxt.addr_latch = {item.read_data, cur.addr_latch[7:0]};
							res.bus_op = BUS_READ; res.bus_address = nxt.addr_latch;
						end else if (r == 3'd4) begin
							nxt.data_latch = item.read_data;
							res.bus_op = BUS_WRITE; res.bus_address = cur.addr_latch;
							res.write_data = 8'hFF;
						end else if (r == 3'd5) begin
							res.execute = 1'b1;
							res.bus_op = BUS_WRITE; res.bus_address = cur.addr_latch;
							res.write_data = item.alu_result;
						end else begin
							done = 1'b1;
						end
					end
				end
				default: begin
					if (s == 3'd1) begin
						res.bus_op = BUS_READ; res.bus_address = cur.pc_reg;
					end else begin
						res.execute = 1'b1; done = 1'b1;
					end
				end
			endcase
			nxt.step = done ? 3'd0 : nstep;
		end
		res.done_res = done;
		res.operand = nxt.data_latch;
		res.effective_address = nxt.addr_latch;
		res.pc_out = nxt.pc_reg;
	end

endmodule

// ===== dv/addr_seq_checker.sv =====
// Checker for the 6502 addressing sequencer: predicts each bus cycle result
// from the accepted input items and compares it with the result channel.
// Depends on c6502as_pkg.
module addr_seq_checker import c6502as_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_item_t out_data,
	output int        fail_count,
	output int        pending,
	output int        cycles_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [2:0]  step;
	logic [3:0]  cur_mode;
	logic [15:0] addr_latch;
	logic [15:0] pc_reg;
	logic [7:0]  data_latch;
	logic        store_f, branch_f;
	logic [7:0]  idx_r, x_r, y_r;
	out_item_t   bus_cycle_q[$];
	out_item_t   r;
	logic [3:0]  nxt;

	assign pending = bus_cycle_q.size();

	function automatic void rd_cycle(input logic [15:0] a);
		r.bus_op = BUS_READ;
		r.bus_address = a;
	endfunction

	function automatic void wr_cycle(input logic [15:0] a, input logic [7:0] d);
		r.bus_op = BUS_WRITE;
		r.bus_address = a;
		r.write_data = d;
	endfunction

	function automatic void fetch_op();
		rd_cycle(pc_reg);
		pc_reg = pc_reg + 16'd1;
	endfunction

	function automatic void store_or_load(input logic [7:0] sd);
		if (store_f)
			wr_cycle(addr_latch, sd);
		else
			rd_cycle(addr_latch);
	endfunction

	function automatic void finish_seq(input logic ex);
		r.execute = ex;
		r.done_res = 1'b1;
	endfunction

	// penalty cycle on store or page cross, else skip straight to the access
	function automatic void add_index(input logic [7:0] ix, input logic [2:0] s);
		logic [15:0] base, sum;
		base = addr_latch;
		sum = base + {8'd0, ix};
		addr_latch = sum;
		if (store_f || sum[15:8] != base[15:8]) begin
			rd_cycle({base[15:8], sum[7:0]});
			nxt = {1'b0, s} + 4'd1;
		end else begin
			rd_cycle(sum);
			nxt = {1'b0, s} + 4'd2;
		end
	endfunction

	function automatic out_item_t predict_cycle(input in_item_t it);
		logic [2:0]  s;
		logic [7:0]  rd;
		logic [15:0] t;
		rd = it.read_data;
		r = '0;
		if (it.kind == KIND_START) begin
			cur_mode = it.mode;
			store_f = it.store_op;
			branch_f = it.branch_taken;
			idx_r = it.index_value;
			x_r = it.x_value;
			y_r = it.y_value;
			pc_reg = it.start_pc;
			addr_latch = '0;
			data_latch = '0;
			step = 3'd1;
		end else if (step != 0) begin
			s = step;
			nxt = {1'b0, s} + 4'd1;
			case (cur_mode)
				M_IMM: begin
					if (s == 1) fetch_op();
					else begin data_latch = rd; finish_seq(1'b1); end
				end
				M_ABS: begin
					if (s == 1) fetch_op();
					else if (s == 2) begin data_latch = rd; fetch_op(); end
					else if (s == 3) begin
						addr_latch = {rd, data_latch};
						store_or_load(it.store_data);
					end else begin
						if (!store_f) data_latch = rd;
						finish_seq(1'b1);
					end
				end
				M_ZP: begin
					if (s == 1) fetch_op();
					else if (s == 2) begin
						addr_latch = {8'd0, rd};
						store_or_load(it.store_data);
					end else begin
						if (!store_f) data_latch = rd;
						finish_seq(1'b1);
					end
				end
				M_ABSX: begin
					if (s == 1) fetch_op();
					else if (s == 2) begin data_latch = rd; fetch_op(); end
					else if (s == 3) begin
						addr_latch = {rd, data_latch};
						add_index(idx_r, s);
					end else if (s == 4) store_or_load(it.store_data);
					else begin
						if (!store_f) data_latch = rd;
						finish_seq(1'b1);
					end
				end
				M_ZPX: begin
					if (s == 1) fetch_op();
					else if (s == 2) begin
						rd_cycle({8'd0, rd});
						addr_latch = {8'd0, rd + idx_r};
					end else if (s == 3) store_or_load(it.store_data);
					else begin
						if (!store_f) data_latch = rd;
						finish_seq(1'b1);
					end
				end
				M_INDX: begin
					if (s == 1) fetch_op();
					else if (s == 2) begin
						data_latch = rd;
						rd_cycle({8'd0, rd});
						data_latch = rd + x_r;
					end else if (s == 3) begin
						rd_cycle({8'd0, data_latch});
						data_latch = data_latch + 8'd1;
					end else if (s == 4) begin
						addr_latch = {8'd0, rd};
						rd_cycle({8'd0, data_latch});
					end else if (s == 5) begin
						addr_latch = {rd, addr_latch[7:0]};
						store_or_load(it.store_data);
					end else begin
						if (!store_f) data_latch = rd;
						finish_seq(1'b1);
					end
				end
				M_INDY: begin
					if (s == 1) fetch_op();
					else if (s == 2) begin
						rd_cycle({8'd0, rd});
						data_latch = rd + 8'd1;
					end else if (s == 3) begin
						addr_latch = {8'd0, rd};
						rd_cycle({8'd0, data_latch});
					end else if (s == 4) begin
						addr_latch = {rd, addr_latch[7:0]};
						add_index(y_r, s);
					end else if (s == 5) store_or_load(it.store_data);
					else begin
						if (!store_f) data_latch = rd;
						finish_seq(1'b1);
					end
				end
				M_REL: begin
					if (s == 1) fetch_op();
					else if (s == 2) begin
						data_latch = rd;
						t = {{8{rd[7]}}, rd};
						addr_latch = pc_reg + t;
						if (branch_f) rd_cycle({pc_reg[15:8], addr_latch[7:0]});
						else finish_seq(1'b0);
					end else if (s == 3 && pc_reg[15:8] != addr_latch[15:8]) begin
						rd_cycle(addr_latch);
					end else begin
						pc_reg = addr_latch;
						finish_seq(1'b0);
					end
				end
				M_ACC: begin
					if (s == 1) begin rd_cycle(pc_reg); data_latch = it.acc_value; end
					else begin r.acc_out = it.alu_result; finish_seq(1'b1); end
				end
				M_ZP_RMW: begin
					if (s == 1) fetch_op();
					else if (s == 2) begin addr_latch = {8'd0, rd}; rd_cycle(addr_latch); end
					else if (s == 3) begin data_latch = rd; wr_cycle(addr_latch, 8'hFF); end
					else if (s == 4) begin
						r.execute = 1'b1;
						wr_cycle(addr_latch, it.alu_result);
					end else finish_seq(1'b0);
				end
				M_ZPX_RMW: begin
					if (s == 1) fetch_op();
					else if (s == 2) begin
						rd_cycle({8'd0, rd});
						addr_latch = {8'd0, rd + idx_r};
					end else if (s == 3) rd_cycle(addr_latch);
					else if (s == 4) begin data_latch = rd; wr_cycle(addr_latch, 8'hFF); end
					else if (s == 5) begin
						r.execute = 1'b1;
						wr_cycle(addr_latch, it.alu_result);
					end else finish_seq(1'b0);
				end
				M_ABS_RMW: begin
					if (s == 1) fetch_op();
					else if (s == 2) begin addr_latch = {8'd0, rd}; fetch_op(); end
					else if (s == 3) begin
						addr_latch = {rd, addr_latch[7:0]};
						rd_cycle(addr_latch);
					end else if (s == 4) begin data_latch = rd; wr_cycle(addr_latch, 8'hFF); end
					else if (s == 5) begin
						r.execute = 1'b1;
						wr_cycle(addr_latch, it.alu_result);
					end else finish_seq(1'b0);
				end
				M_ABSX_RMW: begin
					if (s == 1) fetch_op();
					else if (s == 2) begin data_latch = rd; fetch_op(); end
					else if (s == 3) begin
						rd_cycle({rd, data_latch + idx_r});
						addr_latch = {rd, data_latch} + {8'd0, idx_r};
					end else if (s == 4) rd_cycle(addr_latch);
					else if (s == 5) begin data_latch = rd; wr_cycle(addr_latch, 8'hFF); end
					else if (s == 6) begin
						r.execute = 1'b1;
						wr_cycle(addr_latch, it.alu_result);
					end else finish_seq(1'b0);
				end
				default: begin
					// implied; unused mode codes fall here too
					if (s == 1) rd_cycle(pc_reg);
					else finish_seq(1'b1);
				end
			endcase
			step = r.done_res ? 3'd0 : nxt[2:0];
		end
		r.operand = data_latch;
		r.effective_address = addr_latch;
		r.pc_out = pc_reg;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_item;
		if (!arst_n) begin
			step = '0; cur_mode = '0; addr_latch = '0; pc_reg = '0;
			data_latch = '0; store_f = 1'b0; branch_f = 1'b0;
			idx_r = '0; x_r = '0; y_r = '0;
			fail_count <= 0;
			cycles_seen <= 0;
			bus_cycle_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				cycles_seen <= cycles_seen + 1;
				if (bus_cycle_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result item %p", out_data);
					fail_count <= fail_count + 1;
				end else begin
					exp_item = bus_cycle_q.pop_front();
					if (out_data !== exp_item) begin
						if (fail_count < 10)
							$display("result %0d: expected %p got %p",
								cycles_seen, exp_item, out_data);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && !in_stall)
				bus_cycle_q.push_back(predict_cycle(in_data));
		end
	end
endmodule

// ===== dv/testbench.sv =====
// Top of the addressing sequencer testbench: clock, reset, stimulus and verdict.
// Depends on c6502as_pkg, cpu6502_addressing_sequencer_core and addr_seq_checker.
module testbench;
	import c6502as_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic      clk, arst_n;
	logic      in_valid, in_stall, out_valid, out_stall;
	in_item_t  in_data;
	out_item_t out_data;
	int        fail_count, pending, cycles_seen;
	int        hold_cycles;
	int        n_sent;

	cpu6502_addressing_sequencer_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	addr_seq_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .pending(pending), .cycles_seen(cycles_seen)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		if ($urandom_range(9) < 6) return 0;
		if ($urandom_range(9) < 8) return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	function automatic in_item_t rand_item(input logic k);
		in_item_t    it;
		logic [95:0] rnd;
		rnd = {$urandom, $urandom, $urandom};
		it = rnd[$bits(in_item_t)-1:0];
		it.kind = k;
		return it;
	endfunction

	// valid stays high across back-to-back items; it drops only for a gap
	task automatic send(input in_item_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
	endtask

	// stop offering and wait until every expected result has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// one start item, then enough advance cycles to finish any mode, plus a few idle ones
	task automatic run_instr(input logic [3:0] m, input int extra);
		in_item_t it;
		it = rand_item(KIND_START);
		it.mode = m;
		send(it);
		repeat (7 + extra) send(rand_item(1'b1));
	endtask

	// receiver: random stalls; a long hold-off when requested
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (out_stall) begin
				out_stall <= ($urandom_range(3) == 0);
			end else begin
				out_stall <= ($urandom_range(9) == 0);
			end
		end
	end

	initial begin
		in_item_t it;
		in_valid = 0;
		in_data = '0;
		arst_n = 0;
		hold_cycles = 0;
		n_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// advance while idle, then every mode code including the unused ones
		send(rand_item(1'b1));
		for (int m = 0; m < 16; m++) run_instr(m[3:0], 0);
		// branch taken with page cross, and an abort mid-sequence
		it = '0; it.mode = M_REL; it.branch_taken = 1; it.start_pc = 16'hFFF0;
		send(it);
		it = '1; it.kind = 1'b1; it.read_data = 8'h7F;
		send(it); send(it); send(it);
		it = '1; it.kind = KIND_START; it.mode = M_INDY; it.store_op = 0;
		send(it);
		it.kind = 1'b1; send(it); send(it);
		run_instr(M_ABSX, 0);
		// long receiver hold while the sender keeps offering items
		hold_cycles = 60;
		repeat (20) send(rand_item(1'b1));
		drain();
		for (int i = 0; n_sent < 1850; i++) begin
			if ($urandom_range(19) == 0)
				send(rand_item(1'($urandom_range(1))));
			else
				run_instr(4'($urandom_range(15)), int'($urandom_range(2)));
			if (i == 60) drain();
		end
		drain();
		repeat (10) @(posedge clk);
		$display("Sent %0d items over all 16 mode codes with aborts and stalls;", n_sent);
		$display("checked %0d bus cycle results.", cycles_seen);
		if (fail_count == 0 && pending == 0)
			$display("cpu6502_addressing_sequencer_core: match");
		else
			$display("cpu6502_addressing_sequencer_core: mismatch");
		$finish;
	end

	initial begin
		#5ms;
		$display("cpu6502_addressing_sequencer_core: mismatch");
		$finish;
	end
endmodule
